/* src/issue_port_contention_check_defines.svh */
// Assertion macros shared by the issue port contention check RTL.
// Include by bare file name; each macro expects i_clk and i_rst_n in scope.
`ifndef ISSUE_PORT_CONTENTION_CHECK_DEFINES_SVH
`define ISSUE_PORT_CONTENTION_CHECK_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IPCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IPCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* src/ipcc_pkg.sv */
// Shared types and constants for the issue port contention check.
// No dependencies.
`timescale 1ns / 1ps

package ipcc_pkg;

    localparam int TIME_W    = 40;
    localparam int CLASS_W   = 4;
    localparam int ALU_ID_W  = 2;
    localparam int LAT_W     = 8;
    localparam int INT_CNT_W = 2;

    // Integer ports (P1/P2) that may be claimed in one cycle.
    localparam logic [INT_CNT_W-1:0] INT_PORT_LIMIT = 2'd2;

    // Opcodes of an input item.
    typedef enum logic {
        OP_START_CYCLE = 1'b0,
        OP_TRY_ISSUE   = 1'b1
    } t_opcode;

    // Port classes; every other code claims nothing.
    typedef enum logic [CLASS_W-1:0] {
        CLS_NONE   = 4'd0,
        CLS_P0     = 4'd1,
        CLS_P0_12  = 4'd2,
        CLS_P12    = 4'd3,
        CLS_P3     = 4'd4,
        CLS_P12_3  = 4'd5,
        CLS_P4     = 4'd6,
        CLS_P5     = 4'd7,
        CLS_P6     = 4'd8,
        CLS_P6_12  = 4'd9,
        CLS_P7     = 4'd10,
        CLS_P7_12  = 4'd11
    } t_port_class;

    // Per-cycle port occupancy.
    typedef struct packed {
        logic                 branch;
        logic                 simd0;
        logic                 simd1;
        logic                 multiply;
        logic                 load;
        logic                 store;
        logic [INT_CNT_W-1:0] int_used;
    } t_port_state;

endpackage

/* src/ipcc_port_claim.sv */
// Port claim logic: decides whether a port class can be issued this cycle
// and returns the updated port occupancy. Depends on ipcc_pkg.
`timescale 1ns / 1ps

module ipcc_port_claim import ipcc_pkg::*; (
    input  logic [CLASS_W-1:0] i_port_class,
    input  t_port_state        i_state,
    output logic               o_claim_ok,
    output t_port_state        o_state
);

    logic w_int_free;

    assign w_int_free = (i_state.int_used < INT_PORT_LIMIT);

    // Each class checks its ports; on failure nothing changes.
    always_comb begin
        o_state    = i_state;
        o_claim_ok = 1'b1;
        unique case (i_port_class)
            CLS_P0: begin
                o_claim_ok = !i_state.branch;
                if (o_claim_ok) o_state.branch = 1'b1;
            end
            CLS_P0_12: begin
                o_claim_ok = !i_state.branch && w_int_free;
                if (o_claim_ok) begin
                    o_state.branch   = 1'b1;
                    o_state.int_used = i_state.int_used + 1'b1;
                end
            end
            CLS_P12: begin
                o_claim_ok = w_int_free;
                if (o_claim_ok) o_state.int_used = i_state.int_used + 1'b1;
            end
            CLS_P3: begin
                o_claim_ok = !i_state.multiply;
                if (o_claim_ok) o_state.multiply = 1'b1;
            end
            CLS_P12_3: begin
                o_claim_ok = !i_state.multiply && w_int_free;
                if (o_claim_ok) begin
                    o_state.multiply = 1'b1;
                    o_state.int_used = i_state.int_used + 1'b1;
                end
            end
            CLS_P4: begin
                // Prefers SIMD0, falls back to SIMD1.
                o_claim_ok = !(i_state.simd0 && i_state.simd1);
                if (o_claim_ok) begin
                    if (!i_state.simd0) o_state.simd0 = 1'b1;
                    else                o_state.simd1 = 1'b1;
                end
            end
            CLS_P5: begin
                // Prefers SIMD1, falls back to SIMD0.
                o_claim_ok = !(i_state.simd0 && i_state.simd1);
                if (o_claim_ok) begin
                    if (!i_state.simd1) o_state.simd1 = 1'b1;
                    else                o_state.simd0 = 1'b1;
                end
            end
            CLS_P6: begin
                o_claim_ok = !i_state.load;
                if (o_claim_ok) o_state.load = 1'b1;
            end
            CLS_P6_12: begin
                o_claim_ok = !i_state.load && w_int_free;
                if (o_claim_ok) begin
                    o_state.load     = 1'b1;
                    o_state.int_used = i_state.int_used + 1'b1;
                end
            end
            CLS_P7: begin
                o_claim_ok = !i_state.store;
                if (o_claim_ok) o_state.store = 1'b1;
            end
            CLS_P7_12: begin
                o_claim_ok = !i_state.store && w_int_free;
                if (o_claim_ok) begin
                    o_state.store    = 1'b1;
                    o_state.int_used = i_state.int_used + 1'b1;
                end
            end
            default: begin
                o_claim_ok = 1'b1;
            end
        endcase
    end

endmodule

/* src/issue_port_contention_check.sv */
// Issue port contention check: an accepted item's result is written to the output
// register in the next cycle; one item is accepted every clock while the output is free
// or taken, set by the combinational claim and ALU-busy check. Input is accepted
// while a result waits if that result is taken in the same cycle.
// Synchronous active-low reset clears the time, all port flags, the integer
// port count and every ALU busy-until time. Depends on ipcc_pkg and ipcc_port_claim.
`timescale 1ns / 1ps
`include "issue_port_contention_check_defines.svh"

module issue_port_contention_check import ipcc_pkg::*; #(
    parameter int ALU_COUNT = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_opcode,
    input  logic [TIME_W-1:0]   i_now_cycle,
    input  logic [CLASS_W-1:0]  i_port_class,
    input  logic [ALU_ID_W-1:0] i_alu_id,
    input  logic [LAT_W-1:0]    i_alu_latency,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_granted
);

    localparam int AW = (ALU_COUNT > 1) ? $clog2(ALU_COUNT) : 1;

    logic [TIME_W-1:0] r_cur_time, n_cur_time;
    t_port_state       r_ports, n_ports;
    logic [TIME_W-1:0] r_busy [ALU_COUNT];
    logic              r_out_valid, n_out_valid;
    logic              r_granted, n_granted;

    logic              w_accept;
    logic              w_claim_ok;
    t_port_state       w_claimed;
    logic              w_has_alu;
    logic [AW-1:0]     w_alu_idx;
    logic              w_alu_ok;
    logic              w_granted;
    logic [TIME_W:0]   w_sum;
    logic [TIME_W-1:0] w_busy_next;

    // Handshake: output register frees up when its item is taken.
    assign o_ready   = !r_out_valid || i_ready;
    assign w_accept  = i_valid && o_ready;
    assign o_valid   = r_out_valid;
    assign o_granted = r_granted;

    ipcc_port_claim u_claim (
        .i_port_class (i_port_class),
        .i_state      (r_ports),
        .o_claim_ok   (w_claim_ok),
        .o_state      (w_claimed)
    );

    // ALU busy check; id zero and ids outside the configured count mean no ALU.
    assign w_has_alu = (i_alu_id != '0) && (32'(i_alu_id) < ALU_COUNT);
    assign w_alu_idx = AW'(i_alu_id);
    assign w_alu_ok  = !w_has_alu || !(r_busy[w_alu_idx] > r_cur_time);
    assign w_granted = (i_opcode == OP_TRY_ISSUE) && w_claim_ok && w_alu_ok;

    // New busy-until time saturates at the top of the time range.
    assign w_sum       = {1'b0, r_cur_time} + {{(TIME_W + 1 - LAT_W){1'b0}}, i_alu_latency};
    assign w_busy_next = w_sum[TIME_W] ? {TIME_W{1'b1}} : w_sum[TIME_W-1:0];

    // Next state for time, ports and the result register.
    always_comb begin
        n_cur_time  = r_cur_time;
        n_ports     = r_ports;
        n_out_valid = r_out_valid && !i_ready;
        n_granted   = r_granted;
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_granted   = w_granted;
            if (i_opcode == OP_START_CYCLE) begin
                n_cur_time = i_now_cycle;
                n_ports    = '0;
            end else begin
                // Claimed ports stay claimed even if the ALU refuses.
                n_ports = w_claimed;
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_time  <= '0;
            r_ports     <= '0;
            r_out_valid <= 1'b0;
            r_granted   <= 1'b0;
        end else begin
            r_cur_time  <= n_cur_time;
            r_ports     <= n_ports;
            r_out_valid <= n_out_valid;
            r_granted   <= n_granted;
        end
    end

    // ALU busy-until times, written on a grant that uses the ALU.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ALU_COUNT; k++) begin
                r_busy[k] <= '0;
            end
        end else if (w_accept && w_granted && w_has_alu) begin
            r_busy[w_alu_idx] <= w_busy_next;
        end
    end

    // Checks on the allocator state.
    `IPCC_ASSERT_NOW(a_int_limit, 1'b1, r_ports.int_used <= INT_PORT_LIMIT, "integer port count over limit")
    `IPCC_ASSERT_NEXT(a_start_clears, w_accept && (i_opcode == OP_START_CYCLE), (r_ports == '0) && o_valid && !o_granted, "start-cycle item did not clear ports")
    `IPCC_ASSERT_NEXT(a_busy_after_grant, w_accept && w_granted && w_has_alu, r_busy[$past(w_alu_idx)] >= r_cur_time, "granted ALU busy time below current time")
    `IPCC_ASSERT_NEXT(a_refused_keeps_time, w_accept && (i_opcode == OP_TRY_ISSUE), $stable(r_cur_time), "try-issue item changed current time")

endmodule
